### rtl/core/fsp_pkg.sv
// types, codes and the squelch threshold table shared by the squelch/ptt controller
// no dependencies

package fsp_pkg;

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_SQUELCH_LEVEL = 2'd0,
		REG_RX_TONE_SQL   = 2'd1,
		REG_TX_INHIBIT    = 2'd2
	} reg_idx_t;

	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	// item mode codes
	typedef enum logic [1:0] {
		MODE_TICK    = 2'd0,
		MODE_ENABLE  = 2'd1,
		MODE_DISABLE = 2'd2
	} mode_t;

	// operating state
	typedef enum logic [1:0] {
		OP_OFF = 2'd0,
		OP_RX  = 2'd1,
		OP_TX  = 2'd2
	} op_state_t;

	// tone codes, below DTMF_LIMIT a keypad digit
	localparam logic [3:0] DTMF_LIMIT = 4'd12;
	localparam logic [3:0] TONE_BURST = 4'd12;
	localparam logic [3:0] TONE_NONE  = 4'd13;

	typedef struct packed {
		logic [3:0] squelch_level;
		logic       rx_tone_squelch;
		logic       tx_inhibit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic signed [7:0] rssi;
		logic              tone_detected;
		logic              ptt_pressed;
		logic [3:0]        dtmf_key;
		logic              burst_key;
		logic              rx_path_granted;
		logic              tone_start_ok;
	} item_t;

	typedef struct packed {
		op_state_t  op;
		logic       rf_open;
		logic       audio_open;
		logic       rx_pending;
		logic [3:0] tone;
	} state_t;

	typedef struct packed {
		logic [1:0]        op_status;
		logic              rf_squelch_open;
		logic              speaker_open;
		logic [3:0]        keyed_tone;
		logic              led_green;
		logic              led_red;
		logic signed [7:0] squelch_threshold;
	} result_t;

	// rssi threshold in dBm: -127 + level*66/15, rounded down
	function automatic logic signed [7:0] thr_of(input logic [3:0] level);
		logic signed [7:0] t;
		unique case (level)
			4'd0:  t = -8'sd127;
			4'd1:  t = -8'sd123;
			4'd2:  t = -8'sd119;
			4'd3:  t = -8'sd114;
			4'd4:  t = -8'sd110;
			4'd5:  t = -8'sd105;
			4'd6:  t = -8'sd101;
			4'd7:  t = -8'sd97;
			4'd8:  t = -8'sd92;
			4'd9:  t = -8'sd88;
			4'd10: t = -8'sd83;
			4'd11: t = -8'sd79;
			4'd12: t = -8'sd75;
			4'd13: t = -8'sd70;
			4'd14: t = -8'sd66;
			4'd15: t = -8'sd61;
			default: t = -8'sd127;
		endcase
		return t;
	endfunction

endpackage

### rtl/core/fsp_regs.sv
// configuration registers behind the apb-style port
// depends on fsp_pkg

module fsp_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fsp_pkg::PADDR_W-1:0] paddr,
	input  logic [fsp_pkg::PDATA_W-1:0] pwdata,
	output logic [fsp_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output fsp_pkg::cfg_t               cfg
);
	import fsp_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_SQUELCH_LEVEL: cfg_q.squelch_level   <= pwdata[3:0];
				REG_RX_TONE_SQL:   cfg_q.rx_tone_squelch <= pwdata[0];
				REG_TX_INHIBIT:    cfg_q.tx_inhibit      <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_SQUELCH_LEVEL: prdata[3:0] = cfg_q.squelch_level;
			REG_RX_TONE_SQL:   prdata[0]   = cfg_q.rx_tone_squelch;
			REG_TX_INHIBIT:    prdata[0]   = cfg_q.tx_inhibit;
			default:           prdata      = '0;
		endcase
	end

endmodule

### rtl/core/fsp_core.sv
// per-item update: squelch hysteresis, speaker gate, off/rx/tx control, tone keying, leds
// depends on fsp_pkg

module fsp_core (
	input  fsp_pkg::item_t   item,
	input  fsp_pkg::cfg_t    cfg,
	input  fsp_pkg::state_t  cur,
	output fsp_pkg::state_t  nxt,
	output fsp_pkg::result_t res
);
	import fsp_pkg::*;

	logic signed [7:0] thr;
	logic signed [8:0] thr_hi;
	logic signed [8:0] thr_lo;
	logic signed [8:0] rssi_x;

	assign thr    = thr_of(cfg.squelch_level);
	assign rssi_x = {item.rssi[7], item.rssi};
	assign thr_hi = {thr[7], thr} + 9'sd1;
	assign thr_lo = {thr[7], thr} - 9'sd1;

	always_comb begin
		logic       rf_sql;
		logic       tone_sql;
		logic [3:0] wanted;
		logic       green;
		logic       red;

		nxt      = cur;
		green    = 1'b0;
		red      = 1'b0;
		rf_sql   = 1'b0;
		tone_sql = 1'b0;
		wanted   = TONE_NONE;

		unique case (item.mode)
			MODE_ENABLE: begin
				nxt.rf_open    = 1'b0;
				nxt.audio_open = 1'b0;
				nxt.rx_pending = 1'b1;
			end
			MODE_DISABLE: begin
				nxt.tone       = TONE_NONE;
				nxt.rf_open    = 1'b0;
				nxt.audio_open = 1'b0;
				nxt.rx_pending = 1'b0;
			end
			MODE_TICK: begin
				// receive squelch and speaker gate, or leave off for receive
				if (cur.op == OP_RX) begin
					if (!nxt.rf_open && (rssi_x > thr_hi))
						nxt.rf_open = 1'b1;
					if (nxt.rf_open && (rssi_x < thr_lo))
						nxt.rf_open = 1'b0;
					rf_sql   = !cfg.rx_tone_squelch && nxt.rf_open;
					tone_sql = cfg.rx_tone_squelch && item.tone_detected;
					if (!nxt.audio_open && (rf_sql || tone_sql) && item.rx_path_granted)
						nxt.audio_open = 1'b1;
					if (nxt.audio_open && !rf_sql && !tone_sql)
						nxt.audio_open = 1'b0;
				end else if (cur.op == OP_OFF && cur.rx_pending) begin
					nxt.op         = OP_RX;
					nxt.rx_pending = 1'b0;
				end

				// push-to-talk into transmit
				if (item.ptt_pressed && nxt.op != OP_TX && !cfg.tx_inhibit)
					nxt.op = OP_TX;

				// tone keying, keypad digit before burst
				if (nxt.op == OP_TX) begin
					if (item.dtmf_key < DTMF_LIMIT)
						wanted = item.dtmf_key;
					else if (item.burst_key)
						wanted = TONE_BURST;
				end
				if (wanted != nxt.tone) begin
					nxt.tone = TONE_NONE;
					if (wanted != TONE_NONE && item.tone_start_ok)
						nxt.tone = wanted;
				end

				// key released: back to off, receive on the next tick
				if (!item.ptt_pressed && nxt.op == OP_TX) begin
					nxt.tone       = TONE_NONE;
					nxt.op         = OP_OFF;
					nxt.rx_pending = 1'b1;
					nxt.audio_open = 1'b0;
				end

				// leds
				if (nxt.op == OP_RX) begin
					if (item.tone_detected) begin
						green = 1'b1;
						red   = 1'b1;
					end else if (nxt.rf_open) begin
						green = 1'b1;
					end
				end else if (nxt.op == OP_TX) begin
					red = 1'b1;
				end
			end
			default: ;
		endcase

		res.op_status         = nxt.op;
		res.rf_squelch_open   = nxt.rf_open;
		res.speaker_open      = nxt.audio_open;
		res.keyed_tone        = nxt.tone;
		res.led_green         = green;
		res.led_red           = red;
		res.squelch_threshold = thr;
	end

endmodule

### rtl/core/fm_squelch_ptt_controller.sv
// top level of the fm squelch and push-to-talk controller
// depends on fsp_pkg, fsp_regs, fsp_core

// One result per input transaction. A transaction is captured in an input register and its
// result moves into the output register when that register is free or being taken. A new
// transaction is taken every cycle unless the result stalls; the controller state held beside
// the output register is updated with each result. in_ready drops only while both the
// input register and an untaken result are full. Configuration is written through the
// apb-style port at byte addresses 0 (squelch level), 4 (tone squelch select) and 8 (transmit
// inhibit); pready is always high. Reset leaves the controller off with receive pending.

module fm_squelch_ptt_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fsp_pkg::PADDR_W-1:0] paddr,
	input  logic [fsp_pkg::PDATA_W-1:0] pwdata,
	output logic [fsp_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  mode,
	input  logic signed [7:0]           rssi,
	input  logic                        tone_detected,
	input  logic                        ptt_pressed,
	input  logic [3:0]                  dtmf_key,
	input  logic                        burst_key,
	input  logic                        rx_path_granted,
	input  logic                        tone_start_ok,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  op_status,
	output logic                        rf_squelch_open,
	output logic                        speaker_open,
	output logic [3:0]                  keyed_tone,
	output logic                        led_green,
	output logic                        led_red,
	output logic signed [7:0]           squelch_threshold
);
	import fsp_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    out_valid_q;
	logic    adv;

	fsp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fsp_core u_core (
		.item (item_s1),
		.cfg  (cfg),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// handshake: input stage moves on when the result register is free or being taken
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{mode: mode, rssi: rssi, tone_detected: tone_detected,
				ptt_pressed: ptt_pressed, dtmf_key: dtmf_key, burst_key: burst_key,
				rx_path_granted: rx_path_granted, tone_start_ok: tone_start_ok};
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{op: OP_OFF, rf_open: 1'b0, audio_open: 1'b0,
				rx_pending: 1'b1, tone: TONE_NONE};
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid         = out_valid_q;
	assign op_status         = res_q.op_status;
	assign rf_squelch_open   = res_q.rf_squelch_open;
	assign speaker_open      = res_q.speaker_open;
	assign keyed_tone        = res_q.keyed_tone;
	assign led_green         = res_q.led_green;
	assign led_red           = res_q.led_red;
	assign squelch_threshold = res_q.squelch_threshold;

endmodule

### rtl/core/fsp_checker.sv
// port-level checks on the squelch/ptt controller results, bound to the top level
// depends on fsp_pkg and fm_squelch_ptt_controller

module fsp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [1:0]        op_status,
	input logic [3:0]        keyed_tone,
	input logic              led_green,
	input logic              led_red,
	input logic signed [7:0] squelch_threshold
);
	import fsp_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(op_status) && $stable(keyed_tone))
		else $error("result changed while stalled");

	// a tone is only keyed in transmit
	a_tone_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && keyed_tone != TONE_NONE |-> op_status == OP_TX)
		else $error("tone keyed outside transmit");

	// green only in receive
	a_green_rx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && led_green |-> op_status == OP_RX)
		else $error("green led outside receive");

	// red alone only in transmit
	a_red_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && led_red && !led_green |-> op_status == OP_TX)
		else $error("red led alone outside transmit");

	// threshold within the squelch table
	a_thr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> squelch_threshold >= -8'sd127 && squelch_threshold <= -8'sd61)
		else $error("squelch threshold out of range");

endmodule

bind fm_squelch_ptt_controller fsp_checker u_fsp_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.op_status         (op_status),
	.keyed_tone        (keyed_tone),
	.led_green         (led_green),
	.led_red           (led_red),
	.squelch_threshold (squelch_threshold)
);
